// ===== rtl/core/tfpc_pkg.sv =====
// Shared types and constants for the TCP flow pair counter.
// No dependencies.
package tfpc_pkg;

  localparam logic [15:0] MIN_FRAME      = 16'd54;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] PORT_RESET     = 16'd8080;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_FILTER_ON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PORT     = 8'd1;

  typedef struct packed {
    logic        countable;
    logic [63:0] key;
    logic [31:0] ifx;
  } item_t;

  typedef struct packed {
    logic        counted;
    logic        was_hit;
    logic [63:0] flow_count;
    logic        evicted;
  } res_t;

endpackage

// ===== rtl/core/tcp_flow_pair_counter_top.sv =====
// Per-flow TCP packet counter with an exact-LRU flow table.
// Instantiates tfpc_front and tfpc_back; depends on tfpc_pkg.
//
// Usage: header items enter through a queue-style port (push/full); one
// result per item leaves through a queue-style port (empty/pop), in order.
// Configuration writes (cfg_valid_i, always ready) select the port filter
// (index 0) and the match port (index 1); other indexes are ignored.
// A two-entry queue sits between the classifier and the table engine, and
// the engine drains into a two-entry result queue, so either side stalls
// on its own. The engine handles one item at a time and takes no new item
// until its last result has gone into the result queue. An uncounted
// packet goes straight to its result. With N valid entries a counted
// packet takes a scan of the N entries and a rank-update sweep over them
// (N + 1 entries for an insert into a free slot), both through the single
// read and write port of the table.
// Reset empties the table (fill count to zero), sets the filter on and the
// match port to 8080. When the result queue is full the engine holds its
// finished result, then the item queue fills and full rises.
module tcp_flow_pair_counter_top #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [15:0]                    frame_length_i,
  input  logic [15:0]                    ethertype_i,
  input  logic [7:0]                     ip_protocol_i,
  input  logic [31:0]                    source_address_i,
  input  logic [31:0]                    destination_address_i,
  input  logic [15:0]                    destination_port_i,
  input  logic [31:0]                    interface_index_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           counted_o,
  output logic                           was_hit_o,
  output logic [63:0]                    flow_count_o,
  output logic                           evicted_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tfpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import tfpc_pkg::*;

  logic  item_valid, item_pop;
  item_t item;
  res_t  res;

  tfpc_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .frame_length_i,
    .ethertype_i,
    .ip_protocol_i,
    .source_address_i,
    .destination_address_i,
    .destination_port_i,
    .interface_index_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  tfpc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty,
    .pop,
    .res_o        (res)
  );

  assign counted_o    = res.counted;
  assign was_hit_o    = res.was_hit;
  assign flow_count_o = res.flow_count;
  assign evicted_o    = res.evicted;

endmodule

// ===== rtl/core/tfpc_front.sv =====
// Front part: configuration registers, packet classification and a
// two-entry item queue toward the table engine. Depends on tfpc_pkg.
module tfpc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [15:0]                   frame_length_i,
  input  logic [15:0]                   ethertype_i,
  input  logic [7:0]                    ip_protocol_i,
  input  logic [31:0]                   source_address_i,
  input  logic [31:0]                   destination_address_i,
  input  logic [15:0]                   destination_port_i,
  input  logic [31:0]                   interface_index_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tfpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  output logic                          item_valid_o,
  output tfpc_pkg::item_t               item_o,
  input  logic                          item_pop_i
);
  import tfpc_pkg::*;

  logic        filter_q;
  logic [15:0] port_q;
  item_t       q_mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  item_t       new_item;
  logic        do_push, do_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= 1'b1;
      port_q   <= PORT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PORT_FILTER_ON: filter_q <= cfg_data_i[0];
        CFG_MATCH_PORT:     port_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    new_item.countable = (frame_length_i >= MIN_FRAME) && (ethertype_i == ETHERTYPE_IPV4) &&
                         (ip_protocol_i == PROTO_TCP) &&
                         (!filter_q || (destination_port_i == port_q));
    new_item.key = {source_address_i, destination_address_i};
    new_item.ifx = interface_index_i;
  end

  assign full         = cnt_q[1];
  assign do_push      = push && !cnt_q[1];
  assign item_valid_o = (cnt_q != 2'd0);
  assign do_pop       = item_pop_i && item_valid_o;
  assign item_o       = q_mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem_q[wptr_q] <= new_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/core/tfpc_back.sv =====
// Back part: flow table memory, scan and rank-update sweeps, and a
// two-entry result queue. Depends on tfpc_pkg.
module tfpc_back #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  tfpc_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            empty,
  input  logic            pop,
  output tfpc_pkg::res_t  res_o
);
  import tfpc_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [AW-1:0] MAX_AGE  = AW'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  typedef struct packed {
    logic [63:0]   key;
    logic [63:0]   count;
    logic [31:0]   ifx;
    logic [AW-1:0] age;
  } entry_t;

  entry_t        mem_q [ENTRIES];
  entry_t        rd_data_q, wr_data;
  logic          wr_en;
  logic [AW-1:0] rd_addr;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, lim_q, lim_d, fill_q, fill_d, rank_q, rank_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d, slot_q, slot_d, victim_q, victim_d;
  item_t         item_q, item_d;
  logic          hit_q, hit_d;
  logic [63:0]   cval_q, cval_d, new_count;
  res_t          res_q, res_d;
  logic          issue, is_full;

  res_t          oq_q [2];
  logic          owptr_q, orptr_q;
  logic [1:0]    ocnt_q;
  logic          opush, opop;

  assign is_full   = (fill_q == FULL_CNT);
  assign issue     = ((state_q == ST_SCAN) || (state_q == ST_SWEEP)) && (cnt_q < lim_q);
  assign rd_addr   = cnt_q[AW-1:0];
  assign new_count = hit_q ? (cval_q + 64'd1) : 64'd1;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[rd_idx_q] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    lim_d      = lim_q;
    fill_d     = fill_q;
    rank_d     = rank_q;
    rd_vld_d   = issue;
    rd_idx_d   = rd_addr;
    slot_d     = slot_q;
    victim_d   = victim_q;
    item_d     = item_q;
    hit_d      = hit_q;
    cval_d     = cval_q;
    res_d      = res_q;
    item_pop_o = 1'b0;
    opush      = 1'b0;
    wr_en      = 1'b0;
    wr_data    = rd_data_q;
    if (issue) cnt_d = cnt_q + CW'(1);
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          hit_d      = 1'b0;
          cnt_d      = '0;
          lim_d      = fill_q;
          res_d      = '0;
          state_d    = item_i.countable ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q) begin
          if (!hit_q && (rd_data_q.key == item_q.key)) begin
            hit_d  = 1'b1;
            slot_d = rd_idx_q;
            rank_d = {1'b0, rd_data_q.age};
            cval_d = rd_data_q.count;
          end
          if (rd_data_q.age == MAX_AGE) victim_d = rd_idx_q;
        end else if (!issue) begin
          // scan finished: pick target slot and rank threshold
          cnt_d   = '0;
          state_d = ST_SWEEP;
          if (hit_q) begin
            lim_d = fill_q;
          end else if (is_full) begin
            slot_d = victim_q;
            rank_d = {1'b0, MAX_AGE};
            lim_d  = fill_q;
          end else begin
            slot_d = fill_q[AW-1:0];
            rank_d = FULL_CNT;
            lim_d  = fill_q + CW'(1);
          end
        end
      end
      ST_SWEEP: begin
        if (rd_vld_q) begin
          wr_en = 1'b1;
          if (rd_idx_q == slot_q) begin
            wr_data.key   = item_q.key;
            wr_data.count = new_count;
            wr_data.ifx   = hit_q ? rd_data_q.ifx : item_q.ifx;
            wr_data.age   = '0;
          end else if ({1'b0, rd_data_q.age} < rank_q) begin
            wr_data.age = rd_data_q.age + AW'(1);
          end
        end else if (!issue) begin
          res_d.counted    = 1'b1;
          res_d.was_hit    = hit_q;
          res_d.flow_count = new_count;
          res_d.evicted    = !hit_q && is_full;
          if (!hit_q && !is_full) fill_d = fill_q + CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ocnt_q[1]) begin
          opush   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      lim_q    <= '0;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lim_q    <= lim_d;
      fill_q   <= fill_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q   <= rank_d;
    rd_idx_q <= rd_idx_d;
    slot_q   <= slot_d;
    victim_q <= victim_d;
    item_q   <= item_d;
    cval_q   <= cval_d;
    res_q    <= res_d;
  end

  // result queue
  assign empty = (ocnt_q == 2'd0);
  assign opop  = pop && !empty;
  assign res_o = oq_q[orptr_q];

  always_ff @(posedge clk_i) begin
    if (opush) oq_q[owptr_q] <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= 1'b0;
      orptr_q <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      if (opush) owptr_q <= ~owptr_q;
      if (opop)  orptr_q <= ~orptr_q;
      ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

endmodule
